// ===== rtl/vca_pkg.sv =====
`default_nettype none

package vca_pkg;

  localparam int CHANNELS_DEF = 32;

  // fixed field widths of the stream items
  localparam int OP_W  = 2;
  localparam int CH_W  = 5;
  localparam int STS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PLAY    = 2'd0,
    OP_STOP    = 2'd1,
    OP_BUF_END = 2'd2,
    OP_RSVD    = 2'd3
  } op_e;

  typedef enum logic [STS_W-1:0] {
    ST_GRANT_FREE   = 3'd0,
    ST_GRANT_STOLEN = 3'd1,
    ST_NONE         = 3'd2,
    ST_RELEASED     = 3'd3,
    ST_FLUSH_CLR    = 3'd4,
    ST_IGNORED      = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_UNL_RD,
    S_UNL_WR,
    S_APP_A,
    S_APP_B,
    S_PUSH,
    S_RESP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    latch_in;
    logic    take_free;
    logic    scan_start;
    logic    scan_step;
    logic    sel_cur;
    logic    sel_ch;
    logic    rd_scan;
    logic    unlink_wr;
    logic    app_a;
    logic    app_b;
    logic    set_res;
    status_e res_status;
    logic    load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic fp_full;
    logic ch_playing;
    logic ch_flush;
    logic scan_end;
    logic cur_looping;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/voice_channel_allocator.sv =====
// Playback channel allocator.
// Slave stream carries requests: tuser = opcode (play, stop, buffer end),
// tdata = target channel and loop flag. Master stream returns exactly one
// result transaction per request: tuser = status, tdata = channel and halt.
// Play takes a channel from the free stack; with none free it walks the
// age-ordered in-use list from the oldest end, one node per cycle, and
// steals the first non-looping channel, moving it to the newest end.
// Stop and buffer end release a channel (unlink plus stack push); buffer
// end instead clears the channel's pending flush mark if one is set.
// One request is in flight at a time; the next can be taken in the cycle
// after the previous result is loaded, and a result may sit in the output
// register while the next one is worked on. How long a request takes is
// set by the list walk and the single-port link memories.
// Reset: empty list, all channels free, all flags clear, no result pending.
// A stalled receiver holds the result in the output register; the block
// then finishes its current request and waits before loading the next one.
`default_nettype none

module voice_channel_allocator import vca_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [4:0] channel, [5] loop_flag, [7:6] zero
  input  logic [1:0] s_axis_tuser,   // [1:0] opcode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [4:0] granted_channel, [5] halt_voice, [7:6] zero
  output logic [2:0] m_axis_tuser    // [2:0] status
);

  cmd_t            cmd;
  stat_t           stat;
  logic [CH_W-1:0] out_channel;
  logic            out_halt;

  vca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vca_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_opcode_i   (s_axis_tuser),
    .in_channel_i  (s_axis_tdata[4:0]),
    .in_loop_i     (s_axis_tdata[5]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_status_o  (m_axis_tuser),
    .out_channel_o (out_channel),
    .out_halt_o    (out_halt),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

  assign m_axis_tdata = {2'b00, out_halt, out_channel};

endmodule

`default_nettype wire

// ===== rtl/vca_ctrl.sv =====
`default_nettype none

module vca_ctrl import vca_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   steal_q, steal_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      steal_q <= 1'b0;
    end else begin
      state_q <= state_d;
      steal_q <= steal_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    steal_d = steal_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (stat_i.op)
          OP_PLAY: begin
            steal_d = stat_i.fp_full;
            state_d = stat_i.fp_full ? S_SCAN : S_APP_A;
          end
          OP_STOP: begin
            state_d = stat_i.ch_playing ? S_UNL_RD : S_RESP;
          end
          OP_BUF_END: begin
            if (stat_i.ch_flush)        state_d = S_RESP;
            else if (stat_i.ch_playing) state_d = S_UNL_RD;
            else                        state_d = S_RESP;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_SCAN: begin
        if (stat_i.scan_end)         state_d = S_RESP;
        else if (!stat_i.cur_looping) state_d = S_UNL_RD;
      end
      S_UNL_RD: state_d = S_UNL_WR;
      S_UNL_WR: state_d = (stat_i.op == OP_PLAY) ? S_APP_A : S_PUSH;
      S_APP_A:  state_d = S_APP_B;
      S_APP_B:  state_d = S_RESP;
      S_PUSH:   state_d = S_RESP;
      S_RESP: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = ST_IGNORED;
    in_ready_o       = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      S_DECODE: begin
        case (stat_i.op)
          OP_PLAY: begin
            if (stat_i.fp_full) cmd_o.scan_start = 1'b1;
            else                cmd_o.take_free  = 1'b1;
          end
          OP_STOP: begin
            if (stat_i.ch_playing) cmd_o.sel_ch  = 1'b1;
            else                   cmd_o.set_res = 1'b1;
          end
          OP_BUF_END: begin
            if (stat_i.ch_flush) begin
              cmd_o.set_res    = 1'b1;
              cmd_o.res_status = ST_FLUSH_CLR;
            end else if (stat_i.ch_playing) begin
              cmd_o.sel_ch = 1'b1;
            end else begin
              cmd_o.set_res = 1'b1;
            end
          end
          default: cmd_o.set_res = 1'b1;
        endcase
      end
      S_SCAN: begin
        cmd_o.rd_scan = 1'b1;
        if (stat_i.scan_end) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_NONE;
        end else if (!stat_i.cur_looping) begin
          cmd_o.sel_cur = 1'b1;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_UNL_RD: ;
      S_UNL_WR: cmd_o.unlink_wr = 1'b1;
      S_APP_A:  cmd_o.app_a = 1'b1;
      S_APP_B: begin
        cmd_o.app_b      = 1'b1;
        cmd_o.set_res    = 1'b1;
        cmd_o.res_status = steal_q ? ST_GRANT_STOLEN : ST_GRANT_FREE;
      end
      S_PUSH: begin
        cmd_o.set_res    = 1'b1;
        cmd_o.res_status = ST_RELEASED;
      end
      S_RESP: cmd_o.load_out = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/vca_datapath.sv =====
`default_nettype none

module vca_datapath import vca_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [OP_W-1:0]  in_opcode_i,
  input  logic [CH_W-1:0]  in_channel_i,
  input  logic             in_loop_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [STS_W-1:0] out_status_o,
  output logic [CH_W-1:0]  out_channel_o,
  output logic             out_halt_o,
  input  cmd_t             cmd_i,
  output stat_t            stat_o
);

  localparam int CW = $clog2(CHANNELS);
  localparam int LW = CW + 1;                    // link code, NIL = CHANNELS
  localparam int XW = (LW > CH_W) ? LW : CH_W;   // range check of the input channel
  localparam logic [LW-1:0] NIL = LW'(CHANNELS);

  // latched request
  op_e             op_q;
  logic [CH_W-1:0] ch_q;
  logic            lp_q;

  // control state
  logic [CW-1:0]       c_q, c_d;
  logic [LW-1:0]       fp_q, fp_d;
  logic [LW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [LW-1:0]       k_q, k_d;
  logic                first_q, first_d;
  logic [CHANNELS-1:0] playing_q, playing_d;
  logic [CHANNELS-1:0] looping_q, looping_d;
  logic [CHANNELS-1:0] flush_q, flush_d;
  logic [CHANNELS-1:0] fs_written_q, fs_written_d;

  // memories and their read registers
  logic [CW-1:0] fs_mem [CHANNELS];
  logic [LW-1:0] nx_mem [CHANNELS];
  logic [LW-1:0] pv_mem [CHANNELS];
  logic [CW-1:0] fs_rd_q;
  logic          fs_wr_rd_q;
  logic [LW-1:0] nx_rd_q, pv_rd_q;

  // result and output registers
  status_e         res_status_q, res_status_d;
  logic [CH_W-1:0] res_gch_q, res_gch_d;
  logic            res_halt_q, res_halt_d;
  logic            out_valid_q;
  status_e         out_status_q;
  logic [CH_W-1:0] out_gch_q;
  logic            out_halt_q;

  logic [XW-1:0] ch_x;
  logic          ch_ok;
  logic [CW-1:0] ch_idx, fp_idx, fs_val, cur_idx, nx_raddr;
  logic [LW-1:0] cur, c_link;
  logic          cur_ok;
  logic          n_ok, p_ok, tail_ok;
  logic          push;
  logic          nx_we, pv_we;
  logic [CW-1:0] nx_waddr, pv_waddr;
  logic [LW-1:0] nx_wdata, pv_wdata;

  assign ch_x    = XW'(ch_q);
  assign ch_ok   = ch_x < XW'(CHANNELS);
  assign ch_idx  = CW'(ch_x);
  assign fp_idx  = CW'(fp_q);
  assign fs_val  = fs_wr_rd_q ? fs_rd_q : fp_idx;   // unwritten slot i holds i
  assign cur     = first_q ? head_q : nx_rd_q;
  assign cur_ok  = cur < NIL;
  assign cur_idx = CW'(cur);
  assign c_link  = LW'(c_q);
  assign n_ok    = nx_rd_q < NIL;
  assign p_ok    = pv_rd_q < NIL;
  assign tail_ok = tail_q < NIL;
  assign push    = cmd_i.set_res && (cmd_i.res_status == ST_RELEASED) && (fp_q != '0);
  assign nx_raddr = cmd_i.rd_scan ? cur_idx : c_q;

  assign stat_o.op          = op_q;
  assign stat_o.fp_full     = (fp_q == NIL);
  assign stat_o.ch_playing  = ch_ok && playing_q[ch_idx];
  assign stat_o.ch_flush    = ch_ok && flush_q[ch_idx];
  assign stat_o.scan_end    = (k_q == NIL) || !cur_ok;
  assign stat_o.cur_looping = cur_ok && looping_q[cur_idx];
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  // link memory write ports
  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = c_q;
    nx_wdata = NIL;
    pv_we    = 1'b0;
    pv_waddr = c_q;
    pv_wdata = tail_q;
    if (cmd_i.unlink_wr) begin
      nx_we    = p_ok;
      nx_waddr = CW'(pv_rd_q);
      nx_wdata = nx_rd_q;
      pv_we    = n_ok;
      pv_waddr = CW'(nx_rd_q);
      pv_wdata = pv_rd_q;
    end else if (cmd_i.app_a) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
    end else if (cmd_i.app_b) begin
      nx_we    = tail_ok;
      nx_waddr = CW'(tail_q);
      nx_wdata = c_link;
    end
  end

  // list ends, stack pointer, scan state
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    fp_d    = fp_q;
    c_d     = c_q;
    k_d     = k_q;
    first_d = first_q;
    if (cmd_i.unlink_wr) begin
      if (!p_ok) head_d = nx_rd_q;
      if (!n_ok) tail_d = pv_rd_q;
    end
    if (cmd_i.app_b) begin
      if (!tail_ok) head_d = c_link;
      tail_d = c_link;
    end
    if (cmd_i.take_free) begin
      c_d  = fs_val;
      fp_d = fp_q + 1'b1;
    end
    if (push) fp_d = fp_q - 1'b1;
    if (cmd_i.sel_cur) c_d = cur_idx;
    if (cmd_i.sel_ch)  c_d = ch_idx;
    if (cmd_i.scan_start) begin
      k_d     = '0;
      first_d = 1'b1;
    end
    if (cmd_i.scan_step) begin
      k_d     = k_q + 1'b1;
      first_d = 1'b0;
    end
  end

  // channel flags and result
  always_comb begin
    playing_d    = playing_q;
    looping_d    = looping_q;
    flush_d      = flush_q;
    fs_written_d = fs_written_q;
    res_status_d = res_status_q;
    res_gch_d    = res_gch_q;
    res_halt_d   = res_halt_q;
    if (push) fs_written_d[CW'(fp_q - 1'b1)] = 1'b1;
    if (cmd_i.set_res) begin
      res_status_d = cmd_i.res_status;
      res_gch_d    = ch_q;
      res_halt_d   = 1'b0;
      case (cmd_i.res_status)
        ST_GRANT_FREE, ST_GRANT_STOLEN: begin
          res_gch_d  = CH_W'(c_q);
          res_halt_d = playing_q[c_q];
          if (playing_q[c_q]) flush_d[c_q] = 1'b1;
          playing_d[c_q] = 1'b1;
          looping_d[c_q] = lp_q;
        end
        ST_NONE: res_gch_d = '0;
        ST_RELEASED: begin
          playing_d[c_q] = 1'b0;
          if (op_q == OP_STOP) begin
            flush_d[c_q] = 1'b1;
            res_halt_d   = 1'b1;
          end
        end
        ST_FLUSH_CLR: flush_d[ch_idx] = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q         <= '0;
      head_q       <= NIL;
      tail_q       <= NIL;
      k_q          <= '0;
      first_q      <= 1'b0;
      c_q          <= '0;
      playing_q    <= '0;
      looping_q    <= '0;
      flush_q      <= '0;
      fs_written_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      fp_q         <= fp_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      k_q          <= k_d;
      first_q      <= first_d;
      c_q          <= c_d;
      playing_q    <= playing_d;
      looping_q    <= looping_d;
      flush_q      <= flush_d;
      fs_written_q <= fs_written_d;
      if (cmd_i.load_out)   out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q <= op_e'(in_opcode_i);
      ch_q <= in_channel_i;
      lp_q <= in_loop_i;
    end
    res_status_q <= res_status_d;
    res_gch_q    <= res_gch_d;
    res_halt_q   <= res_halt_d;
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_gch_q    <= res_gch_q;
      out_halt_q   <= res_halt_q;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (push)  fs_mem[CW'(fp_q - 1'b1)] <= c_q;
    if (nx_we) nx_mem[nx_waddr] <= nx_wdata;
    if (pv_we) pv_mem[pv_waddr] <= pv_wdata;
    fs_rd_q    <= fs_mem[fp_idx];
    fs_wr_rd_q <= fs_written_q[fp_idx];
    nx_rd_q    <= nx_mem[nx_raddr];
    pv_rd_q    <= pv_mem[c_q];
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_channel_o = out_gch_q;
  assign out_halt_o    = out_halt_q;

`ifndef SYNTHESIS
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.latch_in |-> ($countones(playing_q) == int'(fp_q)))
    else $error("playing count differs from stack pointer");
  a_list_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.latch_in |-> ((head_q == NIL) == (fp_q == '0)))
    else $error("list head disagrees with stack pointer");
  a_list_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.latch_in |-> ((head_q == NIL) == (tail_q == NIL)))
    else $error("list head and tail disagree");
  a_steal_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.set_res && (cmd_i.res_status == ST_GRANT_STOLEN)) |-> (fp_q == NIL))
    else $error("steal while a channel is free");
  a_release_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.set_res && (cmd_i.res_status == ST_RELEASED)) |-> (fp_q != '0))
    else $error("release with empty in-use count");
`endif

endmodule

`default_nettype wire

// ===== test/tb_voice_channel_allocator.sv =====
`default_nettype none

module tb_voice_channel_allocator;
  import vca_pkg::*;

  localparam int NCH          = CHANNELS_DEF;
  localparam int NIL          = NCH;
  localparam int MAX_GAP      = 17;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = NCH + 12;
  localparam int LIMIT_CYCLES = 200000;
  localparam int NUM_BLOCKS   = 8;

  typedef struct packed {
    status_e         status;
    logic [CH_W-1:0] chan;
    logic            halt;
  } alloc_result_t;

  // one row of the directed table; known = 1 means the result is typed in
  typedef struct packed {
    op_e             op;
    logic [CH_W-1:0] ch;
    logic            lp;
    logic            known;
    status_e         st;
    logic [CH_W-1:0] gch;
    logic            halt;
  } directed_row_t;

  typedef enum int {
    MIX_NOISE,
    MIX_FILL,
    MIX_LOOP_FILL,
    MIX_DRAIN
  } traffic_mix_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [4:0] channel, [5] loop_flag, [7:6] zero
  logic [1:0] s_axis_tuser;   // [1:0] opcode
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [4:0] granted_channel, [5] halt_voice, [7:6] zero
  logic [2:0] m_axis_tuser;   // [2:0] status

  voice_channel_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // shadow copy of the allocator state
  int unsigned spare_stack [NCH];
  int unsigned spare_top;
  int unsigned age_head;
  int unsigned age_tail;
  int unsigned younger [NCH];
  int unsigned older [NCH];
  bit          busy_flag [NCH];
  bit          loop_mark [NCH];
  bit          flush_mark [NCH];

  alloc_result_t pending_results [$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  bit            idle_on = 1'b1;
  bit            hold_long_req = 1'b0;

  directed_row_t directed_rows [20] = '{
    '{OP_STOP,    5'd0,  1'b0, 1'b1, ST_IGNORED,    5'd0,  1'b0},
    '{OP_BUF_END, 5'd31, 1'b0, 1'b1, ST_IGNORED,    5'd31, 1'b0},
    '{OP_RSVD,    5'd21, 1'b1, 1'b1, ST_IGNORED,    5'd21, 1'b0},
    '{OP_PLAY,    5'd31, 1'b0, 1'b1, ST_GRANT_FREE, 5'd0,  1'b0},
    '{OP_PLAY,    5'd0,  1'b1, 1'b1, ST_GRANT_FREE, 5'd1,  1'b0},
    '{OP_BUF_END, 5'd0,  1'b0, 1'b1, ST_RELEASED,   5'd0,  1'b0},
    '{OP_PLAY,    5'd10, 1'b0, 1'b1, ST_GRANT_FREE, 5'd0,  1'b0},
    '{OP_STOP,    5'd0,  1'b0, 1'b1, ST_RELEASED,   5'd0,  1'b1},
    '{OP_BUF_END, 5'd0,  1'b0, 1'b1, ST_FLUSH_CLR,  5'd0,  1'b0},
    '{OP_BUF_END, 5'd0,  1'b0, 1'b1, ST_IGNORED,    5'd0,  1'b0},
    '{OP_STOP,    5'd1,  1'b1, 1'b1, ST_RELEASED,   5'd1,  1'b1},
    '{OP_STOP,    5'd1,  1'b0, 1'b1, ST_IGNORED,    5'd1,  1'b0},
    '{OP_BUF_END, 5'd1,  1'b0, 1'b1, ST_FLUSH_CLR,  5'd1,  1'b0},
    '{OP_PLAY,    5'd0,  1'b1, 1'b1, ST_GRANT_FREE, 5'd1,  1'b0},
    '{OP_PLAY,    5'd0,  1'b0, 1'b1, ST_GRANT_FREE, 5'd0,  1'b0},
    '{OP_PLAY,    5'd0,  1'b1, 1'b1, ST_GRANT_FREE, 5'd2,  1'b0},
    '{OP_RSVD,    5'd10, 1'b0, 1'b1, ST_IGNORED,    5'd10, 1'b0},
    '{OP_BUF_END, 5'd2,  1'b1, 1'b1, ST_RELEASED,   5'd2,  1'b0},
    '{OP_STOP,    5'd1,  1'b0, 1'b0, ST_IGNORED,    5'd0,  1'b0},
    '{OP_PLAY,    5'd0,  1'b0, 1'b0, ST_IGNORED,    5'd0,  1'b0}
  };

  traffic_mix_e block_mix [NUM_BLOCKS] = '{
    MIX_NOISE, MIX_FILL, MIX_LOOP_FILL, MIX_DRAIN,
    MIX_FILL, MIX_LOOP_FILL, MIX_DRAIN, MIX_NOISE
  };
  int unsigned block_len [NUM_BLOCKS] = '{40, 50, 70, 50, 50, 70, 40, 30};

  function automatic void unlink_node(int unsigned c);
    int unsigned n;
    int unsigned p;
    n = younger[c];
    p = older[c];
    if (p < NCH) younger[p] = n; else age_head = n;
    if (n < NCH) older[n] = p; else age_tail = p;
  endfunction

  function automatic void append_node(int unsigned c);
    older[c] = age_tail;
    if (age_tail < NCH) younger[age_tail] = c; else age_head = c;
    younger[c] = NIL;
    age_tail = c;
  endfunction

  function automatic void release_node(int unsigned c);
    unlink_node(c);
    if (spare_top > 0) begin
      spare_top--;
      spare_stack[spare_top] = c;
    end
  endfunction

  // advances the shadow state by one request and returns its result
  function automatic alloc_result_t predict_allocation(op_e op, logic [CH_W-1:0] ch, logic lp);
    alloc_result_t r;
    int unsigned victim;
    int unsigned cur;
    r.status = ST_IGNORED;
    r.chan = ch;
    r.halt = 1'b0;
    case (op)
      OP_PLAY: begin
        victim = NIL;
        if (spare_top < NCH) begin
          victim = spare_stack[spare_top];
          if (victim >= NCH) victim = 0;
          spare_top++;
          append_node(victim);
          r.status = ST_GRANT_FREE;
        end else begin
          // oldest channel that is not looping
          cur = age_head;
          while (cur < NCH && victim == NIL) begin
            if (!loop_mark[cur]) victim = cur;
            cur = younger[cur];
          end
          if (victim < NCH) begin
            unlink_node(victim);
            append_node(victim);
            r.status = ST_GRANT_STOLEN;
          end else begin
            r.status = ST_NONE;
          end
        end
        if (victim < NCH) begin
          if (busy_flag[victim]) begin
            r.halt = 1'b1;
            flush_mark[victim] = 1'b1;
          end
          busy_flag[victim] = 1'b1;
          loop_mark[victim] = lp;
          r.chan = CH_W'(victim);
        end else begin
          r.chan = '0;
        end
      end
      OP_STOP: begin
        if (busy_flag[ch]) begin
          busy_flag[ch] = 1'b0;
          flush_mark[ch] = 1'b1;
          release_node(ch);
          r.status = ST_RELEASED;
          r.halt = 1'b1;
        end
      end
      OP_BUF_END: begin
        if (flush_mark[ch]) begin
          flush_mark[ch] = 1'b0;
          r.status = ST_FLUSH_CLR;
        end else if (busy_flag[ch]) begin
          release_node(ch);
          busy_flag[ch] = 1'b0;
          r.status = ST_RELEASED;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // mostly a channel that is busy or has a flush mark, sometimes any channel
  function automatic logic [CH_W-1:0] pick_channel();
    int unsigned live [$];
    for (int i = 0; i < NCH; i++) begin
      if (busy_flag[i] || flush_mark[i]) live.push_back(i);
    end
    if (live.size() != 0 && $urandom_range(0, 3) != 0) begin
      return CH_W'(live[$urandom_range(0, live.size() - 1)]);
    end
    return CH_W'($urandom_range(0, NCH - 1));
  endfunction

  // offers one request transaction; called at a rising edge
  task automatic send_request(op_e op, logic [CH_W-1:0] ch, logic lp, logic known,
                              alloc_result_t typed_res);
    int unsigned gap;
    alloc_result_t model_res;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, lp, ch};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    model_res = predict_allocation(op, ch, lp);
    pending_results.push_back(known ? typed_res : model_res);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result sink with random back-pressure and one long hold
  initial begin : result_sink
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_long_req) begin
        stall = LONG_HOLD;
        hold_long_req = 1'b0;
      end else begin
        stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin : check_results
    alloc_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: status %0d channel %0d halt %0d",
               m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[5]);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tdata[4:0] !== want.chan) begin
          $error("granted_channel: expected %0d, got %0d", want.chan, m_axis_tdata[4:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[5] !== want.halt) begin
          $error("halt_voice: expected %0d, got %0d", want.halt, m_axis_tdata[5]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    alloc_result_t typed_res;
    op_e           op;
    logic [CH_W-1:0] ch;
    logic          lp;
    int unsigned   roll;

    for (int i = 0; i < NCH; i++) begin
      spare_stack[i] = i;
      younger[i]     = 0;
      older[i]       = 0;
      busy_flag[i]   = 1'b0;
      loop_mark[i]   = 1'b0;
      flush_mark[i]  = 1'b0;
    end
    spare_top = 0;
    age_head  = NIL;
    age_tail  = NIL;

    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_PLAY;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      typed_res.status = directed_rows[i].st;
      typed_res.chan   = directed_rows[i].gch;
      typed_res.halt   = directed_rows[i].halt;
      send_request(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].lp,
                   directed_rows[i].known, typed_res);
    end

    typed_res = '0;
    for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
      // back-to-back traffic in two blocks; the first also starts the long hold
      idle_on = (blk != 1 && blk != 5);
      if (blk == 1) hold_long_req = 1'b1;
      if (blk == 3) begin
        // sender pause until every outstanding result has come back
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      for (int n = 0; n < block_len[blk]; n++) begin
        roll = $urandom_range(0, 99);
        ch   = CH_W'($urandom_range(0, NCH - 1));
        lp   = 1'($urandom_range(0, 1));
        case (block_mix[blk])
          MIX_NOISE: begin
            op = op_e'($urandom_range(0, 3));
            if (op != OP_PLAY && roll < 50) ch = pick_channel();
          end
          MIX_FILL: begin
            op = (roll < 75) ? OP_PLAY : ((roll < 88) ? OP_STOP : OP_BUF_END);
            lp = ($urandom_range(0, 4) == 0);
          end
          MIX_LOOP_FILL: begin
            op = (roll < 92) ? OP_PLAY : ((roll < 96) ? OP_STOP : OP_BUF_END);
            lp = ($urandom_range(0, 9) != 0);
          end
          default: begin
            op = (roll < 30) ? OP_PLAY : ((roll < 60) ? OP_STOP : OP_BUF_END);
          end
        endcase
        if (block_mix[blk] != MIX_NOISE && op != OP_PLAY) ch = pick_channel();
        send_request(op, ch, lp, 1'b0, typed_res);
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/vca_pkg.sv
rtl/vca_ctrl.sv
rtl/vca_datapath.sv
rtl/voice_channel_allocator.sv
test/tb_voice_channel_allocator.sv
